FILE: sv/lzgtc_pkg.sv
// Shared types and constants for the LZ77 greedy token compressor.
package lzgtc_pkg;

   localparam int unsigned WordBits  = 16;
   localparam int unsigned MinWidth  = 4;
   localparam int unsigned ByteBits  = 8;
   localparam int unsigned LwBits    = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
      logic cfg_wr;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

FILE: sv/lzgtc_ctrl.sv
// Controller state machine: item intake, candidate scan, token finish.
module lzgtc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  lzgtc_pkg::status_type sts,
   output lzgtc_pkg::cmd_type   cmd
);
   import lzgtc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            csr_ready  = !req_tvalid;
            cmd.cfg_wr = csr_valid && !req_tvalid;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sts.need_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: sv/lzgtc_dpath.sv
// Datapath: history window, candidate bits, scan pipeline, match state, output register.
module lzgtc_dpath #(
   parameter int unsigned WINDOW_DEPTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lzgtc_pkg::cmd_type    cmd,
   output lzgtc_pkg::status_type sts,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic [3:0]            csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,
   output logic                  rsp_tlast
);
   import lzgtc_pkg::*;

   localparam int unsigned AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW:0]  DepthVal = (AW+1)'(WINDOW_DEPTH);
   localparam logic [AW-1:0] MaxIdx = AW'(WINDOW_DEPTH - 1);

   logic [ByteBits-1:0] hist_mem [WINDOW_DEPTH];
   logic                alive_mem [WINDOW_DEPTH];

   logic [LwBits-1:0]   lw_ff;
   logic [AW-1:0]       wp_ff;
   logic [AW-1:0]       seen_ff;
   logic [15:0]         ml_ff;
   logic [15:0]         best_ff;
   logic [AW-1:0]       lim_ff;
   logic [ByteBits-1:0] b_ff;
   logic                last_ff;
   logic [AW:0]         d_ff;
   logic [AW-1:0]       dq_ff;
   logic                pv_ff;
   logic [AW-1:0]       found_ff;
   logic [ByteBits-1:0] hq_ff;
   logic                aq_ff;
   logic                rsp_valid_ff;
   logic [23:0]         rsp_data_ff;
   logic                rsp_last_ff;

   // effective field width, cap, masks
   logic [3:0]  w;
   logic [15:0] cap, mask, limw, limnew;
   always_comb begin
      w      = (lw_ff < 4'(MinWidth)) ? 4'(MinWidth) : lw_ff;
      cap    = 16'(1) << w;
      mask   = cap - 16'(1);
      limw   = (16'(1) << (5'(WordBits) - {1'b0, w})) - 16'(1);
      limnew = limw;
      if (limnew > 16'(MaxIdx)) limnew = 16'(MaxIdx);
      if (limnew > 16'(seen_ff)) limnew = 16'(seen_ff);
   end

   // scan read address: write position minus distance, wrapped
   logic          issue;
   logic [AW:0]   rsum;
   logic [AW-1:0] raddr;
   logic          hit;
   always_comb begin
      issue = cmd.scan && (d_ff <= {1'b0, lim_ff});
      rsum  = {1'b0, wp_ff} + DepthVal - d_ff;
      if (rsum >= DepthVal) rsum = rsum - DepthVal;
      raddr = rsum[AW-1:0];
      hit   = (hq_ff == b_ff);
   end

   // memories
   always_ff @(posedge clock) begin
      hq_ff <= hist_mem[raddr];
      aq_ff <= alive_mem[d_ff[AW-1:0]];
      if (cmd.finish) hist_mem[wp_ff] <= b_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && pv_ff) begin
         if (ml_ff == 16'd0) begin
            alive_mem[dq_ff] <= hit;
         end else if (aq_ff && !hit) begin
            alive_mem[dq_ff] <= 1'b0;
         end
      end
   end

   // item capture and scan pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (cmd.load) begin
         pv_ff <= 1'b0;
      end else if (cmd.scan) begin
         pv_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         b_ff     <= req_tdata;
         last_ff  <= req_tlast;
         d_ff     <= (AW+1)'(1);
         found_ff <= '0;
         if (ml_ff == 16'd0) lim_ff <= limnew[AW-1:0];
      end else if (cmd.scan) begin
         if (issue) begin
            d_ff  <= d_ff + (AW+1)'(1);
            dq_ff <= d_ff[AW-1:0];
         end
         // first surviving candidate is the smallest distance
         if (pv_ff && hit && (ml_ff == 16'd0 || aq_ff) && found_ff == '0) begin
            found_ff <= dq_ff;
         end
      end
   end

   // token decision
   logic        emit;
   logic [15:0] tok_dist, pword;
   always_comb begin
      emit     = 1'b0;
      tok_dist = best_ff;
      if (ml_ff == 16'd0) begin
         emit     = (found_ff == '0) || last_ff;
         tok_dist = 16'd0;
      end else if (ml_ff >= cap) begin
         emit = 1'b1;
      end else if (found_ff != '0) begin
         emit     = last_ff;
         tok_dist = 16'(found_ff);
      end else begin
         emit = 1'b1;
      end
      pword = (ml_ff == 16'd0) ? 16'd0
            : ((tok_dist << w) | ((ml_ff - 16'd1) & mask));
   end

   // match state and window position
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff   <= 4'(MinWidth);
         wp_ff   <= '0;
         seen_ff <= '0;
         ml_ff   <= '0;
      end else if (cmd.cfg_wr) begin
         lw_ff   <= csr_data;
         wp_ff   <= '0;
         seen_ff <= '0;
         ml_ff   <= '0;
      end else if (cmd.finish) begin
         wp_ff <= (wp_ff == MaxIdx) ? '0 : wp_ff + AW'(1);
         if (seen_ff != MaxIdx) seen_ff <= seen_ff + AW'(1);
         if (emit) begin
            ml_ff <= '0;
         end else if (ml_ff == 16'd0 || found_ff != '0) begin
            ml_ff   <= ml_ff + 16'd1;
            best_ff <= 16'(found_ff);
         end
         if (last_ff) begin
            wp_ff   <= '0;
            seen_ff <= '0;
            ml_ff   <= '0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (cmd.finish && emit) rsp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && emit) begin
         rsp_data_ff <= {b_ff, pword};
         rsp_last_ff <= last_ff;
      end
   end

   assign sts.need_scan = (ml_ff < cap);
   assign sts.scan_done = (d_ff > {1'b0, lim_ff}) && !pv_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign rsp_tlast     = rsp_last_ff;

endmodule

FILE: sv/lz77_greedy_token_compressor_unit.sv
// Top level of the LZ77 greedy token compressor.
//
//  channel | direction | payload
//  req     | in        | tdata[7:0] data_byte, tlast last_byte
//  rsp     | out       | tdata[15:0] pointer_word, [23:16] literal, tlast token_last
//  csr     | in        | data[3:0] length_width
//
// An item is scanned over every candidate distance; candidates run up to the
// smallest of WINDOW_DEPTH-1, 2^(16-w)-1 and the bytes of the block before
// the token started. The scan walks the history memory through one read port
// a cycle. An item after a capped match skips the scan and goes straight to
// the finish state. Reset is synchronous; no clearing pass is needed. A stalled
// rsp holds the token; the next item is taken and waits in the finish state.
module lz77_greedy_token_compressor_unit #(
   parameter int unsigned WINDOW_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // pointer_word, literal
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);
   import lzgtc_pkg::*;

   cmd_type    cmd;
   status_type sts;

   lzgtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lzgtc_dpath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sv/lzgtc_checker.sv
// Port-level checks for the compressor, bound to the top level.
module lzgtc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);
   // a stalled token holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp token changed while stalled");

   // one item at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken while busy");

   // no token right after reset
   a_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind lz77_greedy_token_compressor_unit lzgtc_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
